/* rtl/core/bandlimited_wavetable_oscillator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wavetable oscillator
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANDLIMITED_WAVETABLE_OSCILLATOR_TOP_ASSERT_SVH
`define BANDLIMITED_WAVETABLE_OSCILLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BWO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bwo assertion failed");
`define BWO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bwo assertion failed");
`else
`define BWO_ASSERT_IMP(lbl, ante, cons)
`define BWO_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/bwo_pkg.sv */
// ----------------------------------------------------------------------------
// bwo_pkg
// Types and constants of the band-limited wavetable oscillator.
// ----------------------------------------------------------------------------
package bwo_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TRIGGER = 2'd1,
    OP_STOP    = 2'd2,
    OP_WRITE   = 2'd3
  } bwo_op_t;

  localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
  localparam logic [2:0] REG_BAND_SELECT = 3'd1;
  localparam logic [2:0] REG_WAVE_SHAPE  = 3'd2;
  localparam logic [2:0] REG_BLEND       = 3'd3;
  localparam logic [2:0] REG_DRIVE_GAIN  = 3'd4;
  localparam logic [2:0] REG_OUTPUT_NORM = 3'd5;
  localparam logic [2:0] REG_HARM_GAINS  = 3'd6;

  localparam int          TANH_SIZE = 1024;
  localparam logic [9:0]  TANH_LAST = 10'd1023;
  localparam logic [23:0] TANH_T1   = 24'd16776875;  // tanh(1/128) in Q0.31
  localparam int          SHAPES    = 4;

  typedef enum logic [4:0] {
    ST_I_ZERO,
    ST_I_MUL,
    ST_I_PREP,
    ST_I_DIV,
    ST_I_WR,
    ST_IDLE,
    ST_JOB,
    ST_RA,
    ST_RB,
    ST_IM,
    ST_IS,
    ST_PM,
    ST_PA,
    ST_ADV,
    ST_MIXM,
    ST_MIXS,
    ST_DRV,
    ST_TADDR,
    ST_TLO,
    ST_THI,
    ST_TS,
    ST_NM,
    ST_FIN
  } bwo_state_t;

endpackage

/* rtl/core/bandlimited_wavetable_oscillator_top.sv */
// ----------------------------------------------------------------------------
// bandlimited_wavetable_oscillator_top
// Wavetable oscillator with interpolated table reads, additive partials,
// blend crossfade and tanh soft clip, on one shared multiplier.
// ----------------------------------------------------------------------------
// After reset the block builds its 1024-entry tanh table, one entry after
// another; in_ready stays low until then, while configuration writes are
// taken throughout. Table writes, note trigger and note stop are handled
// in the idle state; a tick with no note active returns zero from there. A
// tick with a note active visits each partial with nonzero gain, and the
// soft clip skips its interpolation when it saturates; every interpolation,
// mix and clip step goes in turn through the single multiplier, and every
// table read through the single read port of the wave table memory.
// A new item is taken once the previous result has been transferred.
// TABLE_SIZE must be a power of two.
`include "bandlimited_wavetable_oscillator_top_assert.svh"

module bandlimited_wavetable_oscillator_top #(
  parameter int TABLE_SIZE = 2048,
  parameter int BANDS      = 10,
  parameter int PARTIALS   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [1:0]         in_table_shape,
  input  logic [3:0]         in_table_band,
  input  logic [10:0]        in_table_index,
  input  logic signed [15:0] in_table_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import bwo_pkg::*;

  localparam int TW    = $clog2(TABLE_SIZE);
  localparam int PW    = TW + 16;
  localparam int ROWS  = SHAPES * BANDS;
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + TW;
  localparam int DEPTH = ROWS * TABLE_SIZE;
  localparam int JW    = $clog2(PARTIALS + 3);
  localparam int PIW   = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;

  // control and configuration
  bwo_state_t          state_r, state_nxt;
  logic                note_r, note_nxt;
  logic [26:0]         step_r, step_nxt;
  logic [3:0]          band_r, band_nxt;
  logic [1:0]          shape_r, shape_nxt;
  logic signed [15:0]  blend_r, blend_nxt;
  logic [15:0]         drive_r, drive_nxt;
  logic [14:0]         norm_r, norm_nxt;
  logic [63:0]         gains_r, gains_nxt;
  logic [PW-1:0]       tphase_r, tphase_nxt;
  logic [PW-1:0]       pphase_r [PARTIALS];
  logic [PW-1:0]       pphase_nxt [PARTIALS];
  logic                out_valid_r, out_valid_nxt;
  logic [JW-1:0]       job_r, job_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [9:0]          k_r, k_nxt;

  // payload
  logic [30:0]         t_r, t_nxt;
  logic [31:0]         den_r, den_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [31:0]         nlo_r, nlo_nxt;
  logic [31:0]         q_r, q_nxt;
  logic signed [58:0]  prod_r;
  logic signed [15:0]  a_r, a_nxt;
  logic signed [15:0]  sine_r, sine_nxt;
  logic signed [15:0]  shp_r, shp_nxt;
  logic signed [15:0]  itp_r, itp_nxt;
  logic signed [35:0]  acc_r, acc_nxt;
  logic [21:0]         mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [9:0]          idx_r, idx_nxt;
  logic [19:0]         frac_r, frac_nxt;
  logic                sat_r, sat_nxt;
  logic [15:0]         lo_r, lo_nxt;
  logic [15:0]         soft_r, soft_nxt;
  logic signed [15:0]  out_sample_r, out_sample_nxt;

  // shared multiplier operands
  logic signed [32:0]  mul_a;
  logic signed [25:0]  mul_b;

  // memories
  logic [15:0]         wt_mem [0:DEPTH-1];
  logic signed [15:0]  wt_q;
  logic                wt_we;
  logic [AW-1:0]       wt_waddr;
  logic [AW-1:0]       wt_raddr;
  logic [15:0]         tanh_mem [0:TANH_SIZE-1];
  logic [15:0]         tanh_q;
  logic                tanh_we;
  logic [15:0]         tanh_wdata;
  logic [9:0]          tanh_raddr;

  // helpers
  logic                in_xfer;
  logic [PIW-1:0]      pidx;
  logic [15:0]         g_cur;
  logic [127:0]        gains_ext;
  logic [PW-1:0]       cur_phase;
  logic [1:0]          cur_shape;
  logic [3:0]          band_eff;
  logic [RW-1:0]       cur_row;
  logic [TW-1:0]       i0, i1;
  logic [31:0]         wr_idx_ext;
  logic [RW-1:0]       wr_row;
  logic signed [21:0]  additive;
  logic signed [21:0]  x_sel;
  logic signed [17:0]  t_sel;
  logic signed [22:0]  mixed;
  logic [16:0]         tdiff;
  logic [32:0]         div_sh;
  logic [32:0]         rnd;
  logic [16:0]         mag_out;
  logic [31:0]         t_sum;
  logic                init_busy;
  logic                tick_busy;

  assign in_ready   = (state_r == ST_IDLE) && !out_valid_r;
  assign in_xfer    = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  assign pidx      = PIW'(job_r - JW'(2));
  assign gains_ext = {64'd0, gains_r};
  assign g_cur     = gains_ext[32'(pidx) * 16 +: 16];
  assign cur_phase = (job_r < JW'(2)) ? tphase_r : pphase_r[pidx];
  assign cur_shape = (job_r == JW'(1)) ? shape_r : 2'd0;
  assign band_eff  = (32'(band_r) >= BANDS) ? 4'(BANDS - 1) : band_r;
  assign cur_row   = RW'(32'(cur_shape) * BANDS + 32'(band_eff));
  assign i0        = cur_phase[PW-1:16];
  assign i1        = i0 + TW'(1);
  assign wr_idx_ext = 32'(in_table_index);
  assign wr_row    = RW'(32'(in_table_shape) * BANDS + 32'(in_table_band));
  assign wt_waddr  = {wr_row, wr_idx_ext[TW-1:0]};
  assign wt_we     = in_xfer && (in_operation == OP_WRITE)
                     && (32'(in_table_band) < BANDS) && (wr_idx_ext < TABLE_SIZE);
  assign wt_raddr  = {cur_row, (state_r == ST_RB) ? i1 : i0};

  assign additive  = 22'(acc_r >>> 14);
  assign x_sel     = (blend_r <= 16'sd0) ? 22'(shp_r) : additive;
  assign t_sel     = (blend_r <= 16'sd0) ? -18'(blend_r) : 18'(blend_r);
  assign mixed     = 23'(sine_r) + 23'(prod_r >>> 15);
  assign tdiff     = {1'b0, tanh_q} - {1'b0, lo_r};
  assign div_sh    = {rem_r, nlo_r[31]};
  assign rnd       = 33'(q_r) + 33'd32768;
  assign mag_out   = prod_r[30:14];
  assign t_sum     = 32'(t_r) + 32'(TANH_T1);

  assign init_busy = (state_r == ST_I_ZERO) || (state_r == ST_I_MUL)
                     || (state_r == ST_I_PREP) || (state_r == ST_I_DIV)
                     || (state_r == ST_I_WR);
  assign tick_busy = !init_busy && (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    note_nxt       = note_r;
    step_nxt       = step_r;
    band_nxt       = band_r;
    shape_nxt      = shape_r;
    blend_nxt      = blend_r;
    drive_nxt      = drive_r;
    norm_nxt       = norm_r;
    gains_nxt      = gains_r;
    tphase_nxt     = tphase_r;
    pphase_nxt     = pphase_r;
    out_valid_nxt  = out_valid_r;
    job_nxt        = job_r;
    cnt_nxt        = cnt_r;
    k_nxt          = k_r;
    t_nxt          = t_r;
    den_nxt        = den_r;
    rem_nxt        = rem_r;
    nlo_nxt        = nlo_r;
    q_nxt          = q_r;
    a_nxt          = a_r;
    sine_nxt       = sine_r;
    shp_nxt        = shp_r;
    itp_nxt        = itp_r;
    acc_nxt        = acc_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    idx_nxt        = idx_r;
    frac_nxt       = frac_r;
    sat_nxt        = sat_r;
    lo_nxt         = lo_r;
    soft_nxt       = soft_r;
    out_sample_nxt = out_sample_r;
    mul_a          = '0;
    mul_b          = '0;
    tanh_we        = 1'b0;
    tanh_wdata     = '0;
    tanh_raddr     = idx_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_I_ZERO: begin
        tanh_we   = 1'b1;
        k_nxt     = 10'd0;
        t_nxt     = '0;
        state_nxt = ST_I_WR;
        q_nxt     = '0;
      end
      ST_I_MUL: begin
        mul_a     = 33'(t_r);
        mul_b     = 26'(TANH_T1);
        state_nxt = ST_I_PREP;
      end
      ST_I_PREP: begin
        den_nxt   = 32'h8000_0000 + 32'(prod_r[54:31]);
        rem_nxt   = {1'b0, t_sum[31:1]};
        nlo_nxt   = {t_sum[0], 31'd0};
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = ST_I_DIV;
      end
      ST_I_DIV: begin
        // restoring division, one quotient bit a cycle
        if (div_sh >= {1'b0, den_r}) begin
          rem_nxt = 32'(div_sh - {1'b0, den_r});
          q_nxt   = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = div_sh[31:0];
          q_nxt   = {q_r[30:0], 1'b0};
        end
        nlo_nxt = {nlo_r[30:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = ST_I_WR;
          k_nxt     = k_r + 10'd1;
        end
      end
      ST_I_WR: begin
        tanh_we    = 1'b1;
        tanh_wdata = (rnd[32:16] > 17'd32767) ? 16'd32767 : rnd[31:16];
        t_nxt      = q_r[30:0];
        if (k_r == TANH_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_I_MUL;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_operation)
            OP_TICK: begin
              if (note_r) begin
                job_nxt   = '0;
                acc_nxt   = '0;
                state_nxt = ST_JOB;
              end else begin
                out_sample_nxt = '0;
                out_valid_nxt  = 1'b1;
              end
            end
            OP_TRIGGER: begin
              note_nxt   = 1'b1;
              tphase_nxt = '0;
              for (int n = 0; n < PARTIALS; n++) begin
                pphase_nxt[n] = '0;
              end
            end
            OP_STOP: begin
              note_nxt   = 1'b0;
              step_nxt   = '0;
              tphase_nxt = '0;
            end
            OP_WRITE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_JOB: begin
        if (job_r == JW'(PARTIALS + 2)) begin
          state_nxt = ST_MIXM;
        end else if ((job_r >= JW'(2)) && (g_cur == 16'd0)) begin
          job_nxt = job_r + JW'(1);
        end else begin
          state_nxt = ST_RA;
        end
      end
      ST_RA: begin
        state_nxt = ST_RB;
      end
      ST_RB: begin
        a_nxt     = wt_q;
        state_nxt = ST_IM;
      end
      ST_IM: begin
        mul_a     = 33'(17'(wt_q) - 17'(a_r));
        mul_b     = 26'({1'b0, cur_phase[15:0]});
        state_nxt = ST_IS;
      end
      ST_IS: begin
        itp_nxt = 16'(32'(a_r) + 32'(prod_r >>> 16));
        if (job_r == JW'(0)) begin
          sine_nxt  = 16'(32'(a_r) + 32'(prod_r >>> 16));
          job_nxt   = job_r + JW'(1);
          state_nxt = ST_JOB;
        end else if (job_r == JW'(1)) begin
          shp_nxt   = 16'(32'(a_r) + 32'(prod_r >>> 16));
          job_nxt   = job_r + JW'(1);
          state_nxt = ST_JOB;
        end else begin
          state_nxt = ST_PM;
        end
      end
      ST_PM: begin
        mul_a     = 33'(itp_r);
        mul_b     = 26'({1'b0, g_cur});
        state_nxt = ST_PA;
      end
      ST_PA: begin
        acc_nxt   = acc_r + 36'(prod_r);
        cnt_nxt   = '0;
        state_nxt = ST_ADV;
      end
      ST_ADV: begin
        // partial n moves n times the step, one add a cycle
        pphase_nxt[pidx] = PW'(32'(pphase_r[pidx]) + 32'(step_r));
        cnt_nxt          = cnt_r + 6'd1;
        if (cnt_r == 6'(pidx)) begin
          job_nxt   = job_r + JW'(1);
          state_nxt = ST_JOB;
        end
      end
      ST_MIXM: begin
        mul_a     = 33'(23'(x_sel) - 23'(sine_r));
        mul_b     = 26'(t_sel);
        state_nxt = ST_MIXS;
      end
      ST_MIXS: begin
        neg_nxt   = mixed[22];
        mag_nxt   = mixed[22] ? 22'(-mixed) : 22'(mixed);
        state_nxt = ST_DRV;
      end
      ST_DRV: begin
        mul_a     = 33'(mag_r);
        mul_b     = 26'(drive_r);
        state_nxt = ST_TADDR;
      end
      ST_TADDR: begin
        sat_nxt    = prod_r[58:20] >= 39'(TANH_LAST);
        idx_nxt    = (prod_r[58:20] >= 39'(TANH_LAST)) ? TANH_LAST : prod_r[29:20];
        tanh_raddr = (prod_r[58:20] >= 39'(TANH_LAST)) ? TANH_LAST : prod_r[29:20];
        frac_nxt   = prod_r[19:0];
        state_nxt  = ST_TLO;
      end
      ST_TLO: begin
        lo_nxt     = tanh_q;
        tanh_raddr = idx_r + 10'd1;
        state_nxt  = ST_THI;
      end
      ST_THI: begin
        if (sat_r || (tanh_q < lo_r)) begin
          soft_nxt  = lo_r;
          state_nxt = ST_NM;
        end else begin
          mul_a     = 33'(tdiff);
          mul_b     = 26'(frac_r);
          state_nxt = ST_TS;
        end
      end
      ST_TS: begin
        soft_nxt  = lo_r + prod_r[35:20];
        state_nxt = ST_NM;
      end
      ST_NM: begin
        mul_a     = 33'(soft_r);
        mul_b     = 26'(norm_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (neg_r) begin
          out_sample_nxt = (mag_out > 17'd32768) ? -16'sd32768 : 16'(-18'(mag_out));
        end else begin
          out_sample_nxt = (mag_out > 17'd32767) ? 16'sd32767 : 16'(mag_out);
        end
        out_valid_nxt = 1'b1;
        tphase_nxt    = PW'(32'(tphase_r) + 32'(step_r));
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_I_ZERO;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP:  step_nxt  = cfg_data[26:0];
        REG_BAND_SELECT: band_nxt  = cfg_data[3:0];
        REG_WAVE_SHAPE:  shape_nxt = cfg_data[1:0];
        REG_BLEND:       blend_nxt = cfg_data[15:0];
        REG_DRIVE_GAIN:  drive_nxt = cfg_data[15:0];
        REG_OUTPUT_NORM: norm_nxt  = cfg_data[14:0];
        REG_HARM_GAINS:  gains_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_I_ZERO;
      note_r      <= 1'b0;
      step_r      <= '0;
      band_r      <= '0;
      shape_r     <= '0;
      blend_r     <= '0;
      drive_r     <= 16'd4096;
      norm_r      <= 15'd21512;
      gains_r     <= '0;
      tphase_r    <= '0;
      for (int n = 0; n < PARTIALS; n++) begin
        pphase_r[n] <= '0;
      end
      out_valid_r <= 1'b0;
      job_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      note_r      <= note_nxt;
      step_r      <= step_nxt;
      band_r      <= band_nxt;
      shape_r     <= shape_nxt;
      blend_r     <= blend_nxt;
      drive_r     <= drive_nxt;
      norm_r      <= norm_nxt;
      gains_r     <= gains_nxt;
      tphase_r    <= tphase_nxt;
      pphase_r    <= pphase_nxt;
      out_valid_r <= out_valid_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    nlo_r        <= nlo_nxt;
    q_r          <= q_nxt;
    prod_r       <= 59'(mul_a) * 59'(mul_b);
    a_r          <= a_nxt;
    sine_r       <= sine_nxt;
    shp_r        <= shp_nxt;
    itp_r        <= itp_nxt;
    acc_r        <= acc_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    idx_r        <= idx_nxt;
    frac_r       <= frac_nxt;
    sat_r        <= sat_nxt;
    lo_r         <= lo_nxt;
    soft_r       <= soft_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // wave tables: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= in_table_value;
    end
    wt_q <= wt_mem[wt_raddr];
  end

  // tanh table, filled by the pass after reset
  always_ff @(posedge clk) begin
    if (tanh_we) begin
      tanh_mem[k_r] <= tanh_wdata;
    end
    tanh_q <= tanh_mem[tanh_raddr];
  end

  `BWO_ASSERT_IMP(a_tick_needs_note, tick_busy, note_r)
  `BWO_ASSERT_IMP(a_silent_phase_zero, !note_r, tphase_r == '0)
  `BWO_ASSERT_NXT(a_no_reinit, !init_busy, !init_busy)
  `BWO_ASSERT_IMP(a_result_source, $rose(out_valid_r), $past(state_r == ST_FIN || state_r == ST_IDLE))
  `BWO_ASSERT_IMP(a_ready_only_idle, in_ready, !tick_busy && !init_busy)

endmodule

/* verif/bandlimited_wavetable_oscillator_top_tb.sv */
// ----------------------------------------------------------------------------
// bandlimited_wavetable_oscillator_top_tb
// Drives table writes, note trigger/stop and ticks through the item channel,
// rewrites the registers between phases, and checks every output sample
// against a cycle-free software model of the oscillator datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bandlimited_wavetable_oscillator_top_tb;
  import bwo_pkg::*;

  localparam int TSIZE  = 2048;
  localparam int NBANDS = 10;
  localparam int NWORDS = SHAPES * NBANDS * TSIZE;
  localparam longint unsigned PH_MOD = longint'(TSIZE) << 16;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_operation = OP_TICK;
  logic [1:0]         in_table_shape = '0;
  logic [3:0]         in_table_band = '0;
  logic [10:0]        in_table_index = '0;
  logic signed [15:0] in_table_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_PHASE_STEP;
  logic [63:0]        cfg_data = '0;

  bandlimited_wavetable_oscillator_top u_dut (.*);

  always #4 clk = ~clk;

  // oscillator model state
  logic signed [15:0] wave_mem [NWORDS];
  bit                 wave_set [NWORDS];
  logic [15:0]        tanh_mem [TANH_SIZE];
  longint unsigned    osc_phase;
  longint unsigned    part_phase [4];
  longint unsigned    osc_step;
  bit                 note_on;
  longint unsigned    r_step, r_band, r_shape, r_drive, r_norm;
  longint             r_blend;
  logic [63:0]        r_gains;

  logic signed [15:0] sample_q [$];
  int errors = 0, mismatches = 0, checked = 0, ticks = 0, writes = 0, cfg_writes = 0;
  int items_sent = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  function automatic void build_tanh();
    longint unsigned t = 0, num, den, q;
    tanh_mem[0] = 16'd0;
    for (int k = 1; k < TANH_SIZE; k++) begin
      num = (t + TANH_T1) << 31;
      den = (64'd1 << 31) + ((t * TANH_T1) >> 31);
      t = num / den;
      q = (t + 32768) >> 16;
      tanh_mem[k] = (q > 32767) ? 16'd32767 : q[15:0];
    end
  endfunction

  function automatic int band_used();
    return (r_band < NBANDS) ? int'(r_band) : NBANDS - 1;
  endfunction

  function automatic int word_addr(int shp, int bnd, longint unsigned ph);
    return (shp * NBANDS + bnd) * TSIZE + int'((ph >> 16) % TSIZE);
  endfunction

  function automatic longint table_read(int shp, longint unsigned ph);
    int     i0 = word_addr(shp, band_used(), ph);
    int     i1 = (i0 % TSIZE == TSIZE - 1) ? i0 - (TSIZE - 1) : i0 + 1;
    longint a = longint'(wave_mem[i0]);
    longint b = longint'(wave_mem[i1]);
    longint f = longint'(ph & 64'hFFFF);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic longint unsigned tanh_clip(longint unsigned mag);
    longint unsigned pos = mag * r_drive;
    longint unsigned idx = pos >> 20;
    longint unsigned frac = pos & 64'hFFFFF;
    longint unsigned lo, hi;
    if (idx >= TANH_SIZE - 1) return tanh_mem[TANH_SIZE-1];
    lo = tanh_mem[idx];
    hi = tanh_mem[idx+1];
    if (hi < lo) return lo;
    return lo + (((hi - lo) * frac) >> 20);
  endfunction

  function automatic logic signed [15:0] osc_sample();
    longint sine, shp, acc = 0, additive, x, t, mixed, y;
    longint unsigned g, mag, mag_out;
    if (!note_on) return 16'sd0;
    sine = table_read(0, osc_phase);
    shp  = table_read(int'(r_shape), osc_phase);
    for (int n = 0; n < 4; n++) begin
      g = (r_gains >> (16 * n)) & 64'hFFFF;
      if (g > 0) begin
        acc += longint'(g) * table_read(0, part_phase[n]);
        part_phase[n] = (part_phase[n] + osc_step * (n + 1)) % PH_MOD;
      end
    end
    additive = acc >>> 14;
    if (r_blend <= 0) begin
      t = -r_blend;
      x = shp;
    end else begin
      t = r_blend;
      x = additive;
    end
    mixed = sine + (((x - sine) * t) >>> 15);
    mag = (mixed < 0) ? longint'(-mixed) : longint'(mixed);
    mag_out = (tanh_clip(mag) * r_norm) >> 14;
    if (mixed < 0) y = (mag_out > 32768) ? -32768 : -longint'(mag_out);
    else y = (mag_out > 32767) ? 32767 : longint'(mag_out);
    osc_phase = (osc_phase + osc_step) % PH_MOD;
    return y[15:0];
  endfunction

  // advance the model by one item; returns 1 when a sample is due
  function automatic bit osc_apply(bwo_op_t op, logic [1:0] shp, logic [3:0] bnd,
                                   logic [10:0] idx, logic [15:0] val,
                                   output logic signed [15:0] smp);
    int a;
    smp = '0;
    case (op)
      OP_TRIGGER: begin
        note_on = 1'b1;
        osc_phase = 0;
        for (int n = 0; n < 4; n++) part_phase[n] = 0;
      end
      OP_STOP: begin
        note_on = 1'b0;
        osc_step = 0;
        osc_phase = 0;
      end
      OP_WRITE: begin
        if (bnd < NBANDS) begin
          a = (int'(shp) * NBANDS + int'(bnd)) * TSIZE + int'(idx);
          wave_mem[a] = val;
          wave_set[a] = 1'b1;
        end
      end
      default: begin
        smp = osc_sample();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic drive_item(bwo_op_t op, logic [1:0] shp, logic [3:0] bnd,
                            logic [10:0] idx, logic [15:0] val);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_operation = op;
    in_table_shape = shp;
    in_table_band = bnd;
    in_table_index = idx;
    in_table_value = val;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fill_word(int shp, longint unsigned ph);
    int a = word_addr(shp, band_used(), ph);
    int b = (a % TSIZE == TSIZE - 1) ? a - (TSIZE - 1) : a + 1;
    logic signed [15:0] dummy;
    if (!wave_set[a]) begin
      void'(osc_apply(OP_WRITE, 2'(shp), 4'(band_used()), 11'(a % TSIZE), rand_value(),
                      dummy));
      drive_item(OP_WRITE, 2'(shp), 4'(band_used()), 11'(a % TSIZE), wave_mem[a]);
      writes++;
    end
    if (!wave_set[b]) begin
      void'(osc_apply(OP_WRITE, 2'(shp), 4'(band_used()), 11'(b % TSIZE), rand_value(),
                      dummy));
      drive_item(OP_WRITE, 2'(shp), 4'(band_used()), 11'(b % TSIZE), wave_mem[b]);
      writes++;
    end
  endtask

  // a tick never reads a table word that has not been written
  task automatic apply_item(bwo_op_t op, logic [1:0] shp, logic [3:0] bnd,
                            logic [10:0] idx, logic [15:0] val,
                            bit typed = 1'b0, logic signed [15:0] typed_smp = '0);
    logic signed [15:0] smp;
    if (op == OP_TICK && note_on) begin
      fill_word(0, osc_phase);
      fill_word(int'(r_shape), osc_phase);
      for (int n = 0; n < 4; n++)
        if (r_gains[16*n +: 16] != 0) fill_word(0, part_phase[n]);
    end
    if (osc_apply(op, shp, bnd, idx, val, smp)) begin
      sample_q.push_back(typed ? typed_smp : smp);
      ticks++;
    end
    if (op == OP_WRITE) writes++;
    drive_item(op, shp, bnd, idx, val);
  endtask

  task automatic write_reg(logic [2:0] ix, logic [63:0] d);
    cfg_index = ix;
    cfg_data = d;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
    case (ix)
      REG_PHASE_STEP: begin
        r_step = d[26:0];
        osc_step = r_step;
      end
      REG_BAND_SELECT: r_band = d[3:0];
      REG_WAVE_SHAPE:  r_shape = d[1:0];
      REG_BLEND:       r_blend = longint'($signed(d[15:0]));
      REG_DRIVE_GAIN:  r_drive = d[15:0];
      REG_OUTPUT_NORM: r_norm = d[14:0];
      default:         r_gains = d;
    endcase
  endtask

  task automatic program_regs(int ph);
    logic [63:0] g;
    in_valid = 1'b0;
    wait (sample_q.size() == 0);
    repeat (100) @(negedge clk);
    if (ph == 0) begin
      write_reg(REG_PHASE_STEP, 0);
      write_reg(REG_BAND_SELECT, 0);
      write_reg(REG_WAVE_SHAPE, 0);
      write_reg(REG_BLEND, 64'hFFFF_FFFF_FFFF_8000);
      write_reg(REG_DRIVE_GAIN, 4096);
      write_reg(REG_OUTPUT_NORM, 16384);
      write_reg(REG_HARM_GAINS, 0);
    end else if (ph == 1) begin
      write_reg(REG_PHASE_STEP, 67108864);
      write_reg(REG_BAND_SELECT, 9);
      write_reg(REG_WAVE_SHAPE, 3);
      write_reg(REG_BLEND, 32767);
      write_reg(REG_DRIVE_GAIN, 64928);
      write_reg(REG_OUTPUT_NORM, 21516);
      write_reg(REG_HARM_GAINS, '1);
    end else begin
      write_reg(REG_PHASE_STEP, ($urandom_range(3) == 0) ? 64'($urandom_range(0, 67108864))
                                                         : 64'($urandom_range(0, 1 << 20)));
      write_reg(REG_BAND_SELECT, 64'($urandom_range(15)));
      write_reg(REG_WAVE_SHAPE, 64'($urandom_range(3)));
      write_reg(REG_BLEND, {48'd0, 16'($urandom)});
      write_reg(REG_DRIVE_GAIN, 64'($urandom_range(4096, 64928)));
      write_reg(REG_OUTPUT_NORM, 64'($urandom_range(16384, 21516)));
      g = {$urandom, $urandom};
      for (int n = 0; n < 4; n++)
        if ($urandom_range(2) == 0) g[16*n +: 16] = '0;
      write_reg(REG_HARM_GAINS, g);
    end
  endtask

  typedef struct {
    bwo_op_t     op;
    logic [1:0]  shp;
    logic [3:0]  bnd;
    logic [10:0] idx;
    logic [15:0] val;
    bit          typed;
    logic [15:0] smp;
  } stim_row_t;

  stim_row_t directed [18] = '{
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b1, 16'h0000},
    '{OP_STOP,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b1, 16'h0000},
    '{OP_WRITE,   2'd0, 4'd0,  11'd0,    16'h7FFF, 1'b0, 16'h0000},
    '{OP_WRITE,   2'd0, 4'd0,  11'd1,    16'h8000, 1'b0, 16'h0000},
    '{OP_WRITE,   2'd0, 4'd0,  11'd2047, 16'h8000, 1'b0, 16'h0000},
    '{OP_WRITE,   2'd3, 4'd9,  11'd2047, 16'h7FFF, 1'b0, 16'h0000},
    '{OP_WRITE,   2'd2, 4'd15, 11'd5,    16'h1234, 1'b0, 16'h0000},
    '{OP_WRITE,   2'd1, 4'd10, 11'd2047, 16'h0007, 1'b0, 16'h0000},
    '{OP_TRIGGER, 2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd3, 4'd15, 11'd2047, 16'hFFFF, 1'b0, 16'h0000},
    '{OP_TRIGGER, 2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_STOP,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b1, 16'h0000},
    '{OP_TRIGGER, 2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000},
    '{OP_TICK,    2'd0, 4'd0,  11'd0,    16'h0000, 1'b0, 16'h0000}
  };

  // runs until count more items, table fills included, have been sent
  task automatic random_items(int count);
    int r;
    int stop_at;
    bwo_op_t op;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (!note_on) op = (r < 60) ? OP_TRIGGER : (r < 80) ? OP_TICK
                        : (r < 90) ? OP_WRITE : OP_STOP;
      else op = (r < 82) ? OP_TICK : (r < 86) ? OP_STOP
              : (r < 90) ? OP_TRIGGER : OP_WRITE;
      apply_item(op, 2'($urandom), 4'($urandom), 11'($urandom), rand_value());
    end
  endtask

  // sample checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected sample %0d", out_sample);
      end else begin
        if (out_sample !== sample_q[0]) begin
          errors++;
          if (mismatches++ < 10)
            $display("sample mismatch: expected %0d got %0d", sample_q[0], out_sample);
        end
        void'(sample_q.pop_front());
        checked++;
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    build_tanh();
    for (int k = 0; k < NWORDS; k++) begin
      wave_mem[k] = '0;
      wave_set[k] = 1'b0;
    end
    osc_phase = 0;
    for (int n = 0; n < 4; n++) part_phase[n] = 0;
    osc_step = 0;
    note_on = 1'b0;
    r_step = 0; r_band = 0; r_shape = 0; r_blend = 0;
    r_drive = 4096; r_norm = 21512; r_gains = '0;
    send_idle_pct = 19;
    recv_stall_pct = 77;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      apply_item(directed[i].op, directed[i].shp, directed[i].bnd, directed[i].idx,
                 directed[i].val, directed[i].typed, directed[i].smp);

    for (int ph = 0; ph < 6; ph++) begin
      program_regs(ph);
      send_idle_pct  = (ph < 2) ? 19 : (ph < 4) ? 77 : 0;
      recv_stall_pct = (ph < 2) ? 77 : (ph < 4) ? 19 : 0;
      random_items(205);
    end

    in_valid = 1'b0;
    wait (sample_q.size() == 0);
    repeat (100) @(posedge clk);
    if (sample_q.size() != 0) errors++;
    $display("covered %0d items: %0d ticks, %0d table writes, %0d register writes",
             items_sent, ticks, writes, cfg_writes);
    $display("%0d samples checked over 6 settings, %0d mismatches", checked, mismatches);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
